FILE: design/rht_pkg.sv
// ----------------------------------------------------------------------------
// rht_pkg: shared types and constants for the handle table
// Operation classes, status codes and fixed field widths.
// ----------------------------------------------------------------------------
package rht_pkg;

   // fixed field widths
   localparam int ID_BITS     = 24;
   localparam int NODE_BITS   = 8;
   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 3;
   localparam int DATA_BITS   = 32;

   localparam logic [ID_BITS-1:0] ID_MAX = 24'hFFFFFF;

   // request kinds as they arrive on the port
   localparam logic [KIND_BITS-1:0] KIND_REGISTER = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_GRAB     = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_RELEASE  = 2'd2;

   // response status codes
   localparam logic [STATUS_BITS-1:0] ST_REGISTERED = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_GRABBED    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_HELD       = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_REMOVED    = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND  = 3'd5;

   // decoded operation handed from front to back
   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_GRAB     = 2'd1,
      OP_RELEASE  = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

endpackage

FILE: design/refcounted_handle_table.sv
// ----------------------------------------------------------------------------
// refcounted_handle_table: reference-counted handle table
// Issues 24-bit ids into an open-addressed slot table, counts grabs and
// releases, and frees a slot when its count reaches zero.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   kind, context_in, handle_in
//   rsp_      out         rsp_valid / rsp_stall   status, handle_out, context_out
//   csr_      in          csr_wr_en               csr_wr_data (node byte)
//
// A transaction passes the intake registers, then waits in a two-entry queue.
// The table engine finishes an unknown kind, or a register on a table at its
// live limit, in the idle state; grab and release pass through the lookup
// state, and a register stays in the probe state until it finds a free slot
// or gives up as full. The slot memories are single-port with registered
// reads. After reset the engine clears the id memory while req_stall stays
// high. rsp_stall holds the result register; intake fills the queue meanwhile.
//
module refcounted_handle_table #(
   parameter int SLOTS        = 256,
   parameter int REF_BITS     = 16,
   parameter int CONTEXT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_context_in,
   input  logic [31:0] req_handle_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_handle_out,
   output logic [31:0] rsp_context_out
);
   import rht_pkg::*;

   localparam int SLOT_BITS = $clog2(SLOTS);
   // queue word: op | context | id | slot
   localparam int SLOT_LO = 0;
   localparam int ID_LO   = SLOT_LO + SLOT_BITS;
   localparam int CTX_LO  = ID_LO + ID_BITS;
   localparam int OP_LO   = CTX_LO + CONTEXT_BITS;
   localparam int Q_WIDTH = OP_LO + 2;

   logic                    clearing;
   logic                    fwd_valid, fwd_stall;
   op_type                  fwd_op;
   logic [CONTEXT_BITS-1:0] fwd_ctx;
   logic [ID_BITS-1:0]      fwd_id;
   logic [SLOT_BITS-1:0]    fwd_slot;

   logic [Q_WIDTH-1:0]      q_wr_data, q_rd_data;
   logic                    q_valid, q_pop;
   op_type                  q_op;

   // intake and classification
   rht_front #(
      .SLOTS        (SLOTS),
      .CONTEXT_BITS (CONTEXT_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .clearing       (clearing),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_context_in (req_context_in),
      .req_handle_in  (req_handle_in),
      .fwd_valid      (fwd_valid),
      .fwd_stall      (fwd_stall),
      .fwd_op         (fwd_op),
      .fwd_ctx        (fwd_ctx),
      .fwd_id         (fwd_id),
      .fwd_slot       (fwd_slot)
   );

   assign q_wr_data = {2'(fwd_op), fwd_ctx, fwd_id, fwd_slot};
   assign q_op      = op_type'(q_rd_data[OP_LO +: 2]);

   // decoupling queue
   rht_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fwd_valid),
      .wr_stall (fwd_stall),
      .wr_data  (q_wr_data),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_data  (q_rd_data)
   );

   // table engine
   rht_back #(
      .SLOTS        (SLOTS),
      .REF_BITS     (REF_BITS),
      .CONTEXT_BITS (CONTEXT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .clearing        (clearing),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_op            (q_op),
      .q_ctx           (q_rd_data[CTX_LO +: CONTEXT_BITS]),
      .q_id            (q_rd_data[ID_LO +: ID_BITS]),
      .q_slot          (q_rd_data[SLOT_LO +: SLOT_BITS]),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_context_out (rsp_context_out)
   );

`ifndef SYNTHESIS
   // no result and no intake while the id memory is being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!rsp_valid && req_stall))
      else $error("activity during clearing pass");

   // engine starts a transaction only when the result register can take it
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_valid || !rsp_stall))
      else $error("transaction started with result register blocked");

   // a handle is returned only on successful registration
   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_REGISTERED) |-> (rsp_handle_out == '0))
      else $error("handle on non-register result");

   // failures and registrations carry no context
   a_ctx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND ||
                     rsp_status == ST_REGISTERED)) |-> (rsp_context_out == '0))
      else $error("context on result that carries none");
`endif

endmodule

FILE: design/rht_front.sv
// ----------------------------------------------------------------------------
// rht_front: request intake and classification
// Takes transactions, decodes the kind, masks the id and computes its home
// slot (id mod SLOTS) by a reciprocal multiply over two stages.
// ----------------------------------------------------------------------------
module rht_front #(
   parameter int SLOTS        = 256,
   parameter int CONTEXT_BITS = 32,
   localparam int SLOT_BITS   = $clog2(SLOTS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clearing,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_kind,
   input  logic [31:0]             req_context_in,
   input  logic [31:0]             req_handle_in,
   output logic                    fwd_valid,
   input  logic                    fwd_stall,
   output rht_pkg::op_type         fwd_op,
   output logic [CONTEXT_BITS-1:0] fwd_ctx,
   output logic [23:0]             fwd_id,
   output logic [SLOT_BITS-1:0]    fwd_slot
);
   import rht_pkg::*;

   // quotient = (id * RECIP) >> SHIFT is exact for every 24-bit id
   localparam int SHIFT      = ID_BITS + SLOT_BITS;
   localparam int RECIP_BITS = ID_BITS + 2;
   localparam int PROD_BITS  = ID_BITS + RECIP_BITS;
   localparam logic [63:0] RECIP64 =
      ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP64);
   localparam logic [ID_BITS-1:0] SLOTS_ID = ID_BITS'(SLOTS);

   // stage 1: captured transaction
   logic                    s1_valid_ff, s1_valid_in;
   logic [KIND_BITS-1:0]    s1_kind_ff;
   logic [CONTEXT_BITS-1:0] s1_ctx_ff;
   logic [ID_BITS-1:0]      s1_id_ff;

   // stage 2: classified, quotient known
   logic                    s2_valid_ff, s2_valid_in;
   op_type                  s2_op_ff, s2_op_in;
   logic [CONTEXT_BITS-1:0] s2_ctx_ff;
   logic [ID_BITS-1:0]      s2_id_ff;
   logic [ID_BITS-1:0]      s2_quot_ff, s2_quot_in;

   logic                    s1_adv, s2_adv, req_take;
   logic [PROD_BITS-1:0]    quot_prod;
   logic [ID_BITS-1:0]      back_prod;

   // advance when the next stage is empty or moving
   assign s2_adv    = !s2_valid_ff || !fwd_stall;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_stall = !s1_adv || clearing;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   // reciprocal multiply for the quotient
   assign quot_prod  = PROD_BITS'(s1_id_ff) * PROD_BITS'(RECIP);
   assign s2_quot_in = ID_BITS'(quot_prod >> SHIFT);

   // classify: grab and release of id zero never match
   always_comb begin
      case (s1_kind_ff)
         KIND_REGISTER: s2_op_in = OP_REGISTER;
         KIND_GRAB:     s2_op_in = (s1_id_ff != '0) ? OP_GRAB : OP_NONE;
         KIND_RELEASE:  s2_op_in = (s1_id_ff != '0) ? OP_RELEASE : OP_NONE;
         default:       s2_op_in = OP_NONE;
      endcase
   end

   // remainder from the registered quotient
   assign back_prod = ID_BITS'(s2_quot_ff * SLOTS_ID);

   assign fwd_valid = s2_valid_ff;
   assign fwd_op    = s2_op_ff;
   assign fwd_ctx   = s2_ctx_ff;
   assign fwd_id    = s2_id_ff;
   assign fwd_slot  = SLOT_BITS'(s2_id_ff - back_prod);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff <= req_kind;
         s1_ctx_ff  <= CONTEXT_BITS'(req_context_in);
         s1_id_ff   <= req_handle_in[ID_BITS-1:0];
      end
      if (s2_adv && s1_valid_ff) begin
         s2_op_ff   <= s2_op_in;
         s2_ctx_ff  <= s1_ctx_ff;
         s2_id_ff   <= s1_id_ff;
         s2_quot_ff <= s2_quot_in;
      end
   end

endmodule

FILE: design/rht_queue.sv
// ----------------------------------------------------------------------------
// rht_queue: short FIFO between front and back
// Lets intake keep taking transactions while the table engine is busy.
// ----------------------------------------------------------------------------
module rht_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_stall,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_pop,
   output logic [WIDTH-1:0] rd_data
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign wr_stall = (count_ff == CNT_BITS'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign push     = wr_valid && !wr_stall;
   assign pop      = rd_pop && rd_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: design/rht_back.sv
// ----------------------------------------------------------------------------
// rht_back: table engine
// Owns the slot memories, runs the clearing pass after reset, probes for a
// free slot on register and does the count update on grab and release.
// ----------------------------------------------------------------------------
module rht_back #(
   parameter int SLOTS        = 256,
   parameter int REF_BITS     = 16,
   parameter int CONTEXT_BITS = 32,
   localparam int SLOT_BITS   = $clog2(SLOTS)
) (
   input  logic                    clock,
   input  logic                    reset,
   output logic                    clearing,
   input  logic                    csr_wr_en,
   input  logic [7:0]              csr_wr_data,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  rht_pkg::op_type         q_op,
   input  logic [CONTEXT_BITS-1:0] q_ctx,
   input  logic [23:0]             q_id,
   input  logic [SLOT_BITS-1:0]    q_slot,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [31:0]             rsp_handle_out,
   output logic [31:0]             rsp_context_out
);
   import rht_pkg::*;

   localparam int LIVE_BITS  = $clog2(SLOTS + 1);
   localparam int PROBE_BITS = $clog2(SLOTS + 2);
   localparam logic [LIVE_BITS-1:0]  LIVE_LIMIT  = LIVE_BITS'((SLOTS * 3) / 4);
   localparam logic [PROBE_BITS-1:0] PROBE_LIMIT = PROBE_BITS'(SLOTS + 1);
   localparam logic [SLOT_BITS-1:0]  SLOT_LAST   = SLOT_BITS'(SLOTS - 1);
   localparam logic [REF_BITS-1:0]   REF_MAX     = {REF_BITS{1'b1}};

   // engine states
   localparam logic [1:0] BK_CLEAR  = 2'd0;
   localparam logic [1:0] BK_IDLE   = 2'd1;
   localparam logic [1:0] BK_PROBE  = 2'd2;
   localparam logic [1:0] BK_LOOKUP = 2'd3;

   // slot memories
   logic [ID_BITS-1:0]      slot_id_ff   [SLOTS];
   logic [REF_BITS-1:0]     slot_refs_ff [SLOTS];
   logic [CONTEXT_BITS-1:0] slot_ctx_ff  [SLOTS];

   logic [ID_BITS-1:0]      rd_id_ff;
   logic [REF_BITS-1:0]     rd_refs_ff;
   logic [CONTEXT_BITS-1:0] rd_ctx_ff;

   logic                    rd_en;
   logic [SLOT_BITS-1:0]    rd_addr, wr_addr;
   logic                    id_we, refs_we, ctx_we;
   logic [ID_BITS-1:0]      wr_id;
   logic [REF_BITS-1:0]     wr_refs;

   // control state
   logic [1:0]              state_ff, state_in;
   logic [SLOT_BITS-1:0]    clr_ff, clr_in;
   logic [ID_BITS-1:0]      last_id_ff, last_id_in;
   logic [SLOT_BITS-1:0]    last_slot_ff, last_slot_in;
   logic [LIVE_BITS-1:0]    live_ff, live_in;
   logic [NODE_BITS-1:0]    node_ff, node_in;
   logic [PROBE_BITS-1:0]   probes_ff, probes_in;

   // transaction in progress
   op_type                  cur_op_ff;
   logic [CONTEXT_BITS-1:0] cur_ctx_ff;
   logic [ID_BITS-1:0]      cur_id_ff;

   // slot of the lookup in progress, kept for the write back
   logic [SLOT_BITS-1:0]    rd_addr_hold;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [DATA_BITS-1:0]    rsp_handle_ff, rsp_handle_in;
   logic [DATA_BITS-1:0]    rsp_ctx_ff, rsp_ctx_in;

   logic                    out_free, fin;
   logic [STATUS_BITS-1:0]  fin_status;
   logic [DATA_BITS-1:0]    fin_handle, fin_ctx;
   logic [ID_BITS-1:0]      nxt_id;
   logic [SLOT_BITS-1:0]    nxt_slot;
   logic [REF_BITS-1:0]     rel_refs;

   assign clearing        = (state_ff == BK_CLEAR);
   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_out  = rsp_handle_ff;
   assign rsp_context_out = rsp_ctx_ff;

   // next candidate id; its slot follows along, id wrap lands on slot one
   assign nxt_id   = (last_id_ff == ID_MAX) ? ID_BITS'(1) : last_id_ff + ID_BITS'(1);
   assign nxt_slot = (last_id_ff == ID_MAX) ? SLOT_BITS'(1) :
                     ((last_slot_ff == SLOT_LAST) ? '0 : last_slot_ff + SLOT_BITS'(1));

   assign rel_refs = (rd_refs_ff == '0) ? '0 : rd_refs_ff - REF_BITS'(1);

   // engine sequencing
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      last_id_in   = last_id_ff;
      last_slot_in = last_slot_ff;
      live_in      = live_ff;
      probes_in    = probes_ff;
      node_in      = csr_wr_en ? csr_wr_data : node_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_addr      = '0;
      id_we        = 1'b0;
      refs_we      = 1'b0;
      ctx_we       = 1'b0;
      wr_id        = '0;
      wr_refs      = '0;
      fin          = 1'b0;
      fin_status   = ST_NOT_FOUND;
      fin_handle   = '0;
      fin_ctx      = '0;

      case (state_ff)
         BK_CLEAR: begin
            id_we   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + SLOT_BITS'(1);
            if (clr_ff == SLOT_LAST) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_op)
                  OP_REGISTER: begin
                     if (live_ff >= LIVE_LIMIT) begin
                        fin        = 1'b1;
                        fin_status = ST_FULL;
                     end else begin
                        last_id_in   = nxt_id;
                        last_slot_in = nxt_slot;
                        rd_en        = 1'b1;
                        rd_addr      = nxt_slot;
                        probes_in    = PROBE_BITS'(1);
                        state_in     = BK_PROBE;
                     end
                  end
                  OP_GRAB, OP_RELEASE: begin
                     rd_en    = 1'b1;
                     rd_addr  = q_slot;
                     state_in = BK_LOOKUP;
                  end
                  default: begin
                     fin        = 1'b1;
                     fin_status = ST_NOT_FOUND;
                  end
               endcase
            end
         end
         BK_PROBE: begin
            // last_id/last_slot hold the candidate just read
            if (rd_id_ff == '0) begin
               id_we      = 1'b1;
               refs_we    = 1'b1;
               ctx_we     = 1'b1;
               wr_addr    = last_slot_ff;
               wr_id      = last_id_ff;
               wr_refs    = REF_BITS'(1);
               live_in    = live_ff + LIVE_BITS'(1);
               fin        = 1'b1;
               fin_status = ST_REGISTERED;
               fin_handle = {node_ff, last_id_ff};
               state_in   = BK_IDLE;
            end else if (probes_ff == PROBE_LIMIT) begin
               fin        = 1'b1;
               fin_status = ST_FULL;
               state_in   = BK_IDLE;
            end else begin
               last_id_in   = nxt_id;
               last_slot_in = nxt_slot;
               rd_en        = 1'b1;
               rd_addr      = nxt_slot;
               probes_in    = probes_ff + PROBE_BITS'(1);
            end
         end
         BK_LOOKUP: begin
            state_in = BK_IDLE;
            fin      = 1'b1;
            wr_addr  = rd_addr_hold;
            if (rd_id_ff != cur_id_ff) begin
               fin_status = ST_NOT_FOUND;
            end else if (cur_op_ff == OP_GRAB) begin
               refs_we    = 1'b1;
               wr_refs    = (rd_refs_ff == REF_MAX) ? rd_refs_ff
                                                    : rd_refs_ff + REF_BITS'(1);
               fin_status = ST_GRABBED;
               fin_ctx    = DATA_BITS'(rd_ctx_ff);
            end else begin
               refs_we = 1'b1;
               wr_refs = rel_refs;
               fin_ctx = DATA_BITS'(rd_ctx_ff);
               if (rel_refs != '0) begin
                  fin_status = ST_HELD;
               end else begin
                  id_we      = 1'b1;
                  fin_status = ST_REMOVED;
                  if (live_ff != '0) begin
                     live_in = live_ff - LIVE_BITS'(1);
                  end
               end
            end
         end
         default: begin
            state_in = BK_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_addr_hold <= q_slot;
      end
   end

   // result register: hold while stalled, load on completion
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_ctx_in    = rsp_ctx_ff;
      if (fin) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         rsp_handle_in = fin_handle;
         rsp_ctx_in    = fin_ctx;
      end
   end

   // memories with registered read
   always_ff @(posedge clock) begin
      if (id_we) begin
         slot_id_ff[wr_addr] <= wr_id;
      end
      if (refs_we) begin
         slot_refs_ff[wr_addr] <= wr_refs;
      end
      if (ctx_we) begin
         slot_ctx_ff[wr_addr] <= cur_ctx_ff;
      end
      if (rd_en) begin
         rd_id_ff   <= slot_id_ff[rd_addr];
         rd_refs_ff <= slot_refs_ff[rd_addr];
         rd_ctx_ff  <= slot_ctx_ff[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         last_id_ff   <= '0;
         last_slot_ff <= '0;
         live_ff      <= '0;
         node_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         last_id_ff   <= last_id_in;
         last_slot_ff <= last_slot_in;
         live_ff      <= live_in;
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      probes_ff     <= probes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_ctx_ff    <= rsp_ctx_in;
      if (q_pop) begin
         cur_op_ff  <= q_op;
         cur_ctx_ff <= q_ctx;
         cur_id_ff  <= q_id;
      end
   end

endmodule
